FILE: hdl/xpr_pkg.sv
// ----------------------------------------------------------------------------
// xpr_pkg
// shared types, protocol bytes and result codes of the xmodem receiver
// ----------------------------------------------------------------------------
package xpr_pkg;

    localparam int PAYLOAD_BYTES = 128;
    localparam int PAGE_BYTES    = 64;
    localparam int ADDR_BITS     = 16;
    localparam int IDX_BITS      = $clog2(PAYLOAD_BYTES);

    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    // protocol bytes
    localparam logic [7:0] BYTE_SOH   = 8'h01;
    localparam logic [7:0] BYTE_EOT   = 8'h04;
    localparam logic [7:0] BYTE_ACK   = 8'h06;
    localparam logic [7:0] BYTE_NAK   = 8'h15;
    localparam logic [7:0] BYTE_FATAL = 8'h45;

    // result kinds
    localparam logic [2:0] KIND_STAGE  = 3'd0;
    localparam logic [2:0] KIND_COMMIT = 3'd1;
    localparam logic [2:0] KIND_NAK    = 3'd2;
    localparam logic [2:0] KIND_END    = 3'd3;
    localparam logic [2:0] KIND_FATAL  = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE     = 3'd0;
    localparam logic [2:0] ERR_START    = 3'd1;
    localparam logic [2:0] ERR_INVERT   = 3'd2;
    localparam logic [2:0] ERR_ORDER    = 3'd3;
    localparam logic [2:0] ERR_CHECKSUM = 3'd4;
    localparam logic [2:0] ERR_ADDRESS  = 3'd5;

    // register indexes
    localparam logic REG_ENABLE_CHECKS  = 1'b0;
    localparam logic REG_APP_END_OFFSET = 1'b1;

    localparam logic        ENABLE_CHECKS_RESET  = 1'b1;
    localparam logic [15:0] APP_END_OFFSET_RESET = 16'd7168;

    // output packing widths
    localparam int TDATA_FIELDS = 8 + IDX_BITS + 8 + 16 + 3;
    localparam int TDATA_BITS   = ((TDATA_FIELDS + 7) / 8) * 8;

    // classified byte handed from front to back
    typedef struct packed {
        logic [7:0] data;
        logic       is_soh;
        logic       is_eot;
    } rx_item_t;

    typedef struct packed {
        logic [2:0]          kind;
        logic [7:0]          tx_byte;
        logic [IDX_BITS-1:0] stage_index;
        logic [7:0]          stage_data;
        logic [15:0]         flash_offset;
        logic [2:0]          error_code;
    } result_t;

endpackage

FILE: hdl/xpr_front.sv
// ----------------------------------------------------------------------------
// xpr_front
// input stage: registers received bytes and flags start and end bytes
// ----------------------------------------------------------------------------
module xpr_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         in_byte,
    output logic               q_valid,
    input  logic               q_ready,
    output xpr_pkg::rx_item_t  q_item
);

    logic              valid_reg;
    logic              valid_next;
    xpr_pkg::rx_item_t item_reg;

    assign in_ready = !valid_reg || q_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg.data   <= in_byte;
            item_reg.is_soh <= (in_byte == xpr_pkg::BYTE_SOH);
            item_reg.is_eot <= (in_byte == xpr_pkg::BYTE_EOT);
        end
    end

    assign q_valid = valid_reg;
    assign q_item  = item_reg;

endmodule

FILE: hdl/xpr_queue.sv
// ----------------------------------------------------------------------------
// xpr_queue
// small fifo that decouples the input stage from the packet engine
// ----------------------------------------------------------------------------
module xpr_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  xpr_pkg::rx_item_t  wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output xpr_pkg::rx_item_t  rd_item
);

    xpr_pkg::rx_item_t                mem [xpr_pkg::QUEUE_DEPTH];
    logic [xpr_pkg::QUEUE_AW-1:0]     wr_ptr_reg;
    logic [xpr_pkg::QUEUE_AW-1:0]     wr_ptr_next;
    logic [xpr_pkg::QUEUE_AW-1:0]     rd_ptr_reg;
    logic [xpr_pkg::QUEUE_AW-1:0]     rd_ptr_next;
    logic [xpr_pkg::QUEUE_AW:0]       count_reg;
    logic [xpr_pkg::QUEUE_AW:0]       count_next;
    logic                             push;
    logic                             pop;

    assign wr_ready = (count_reg != (xpr_pkg::QUEUE_AW+1)'(xpr_pkg::QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_item  = mem[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

FILE: hdl/xpr_back.sv
// ----------------------------------------------------------------------------
// xpr_back
// packet engine: parses the byte stream and registers at most one result per byte
// ----------------------------------------------------------------------------
module xpr_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               enable_checks,
    input  logic [15:0]        app_end_offset,
    input  logic               q_valid,
    output logic               q_ready,
    input  xpr_pkg::rx_item_t  q_item,
    output logic               out_valid,
    input  logic               out_ready,
    output xpr_pkg::result_t   out_result
);

    typedef enum logic [2:0] {
        PH_START,
        PH_NUMBER,
        PH_COMPL,
        PH_DATA,
        PH_SUM,
        PH_DONE,
        PH_HALT
    } phase_t;

    localparam int IW = xpr_pkg::IDX_BITS;
    localparam int AW = xpr_pkg::ADDR_BITS;

    phase_t                  phase_reg;
    phase_t                  phase_next;
    logic [7:0]              rx_num_reg;
    logic [7:0]              rx_num_next;
    logic [7:0]              exp_num_reg;
    logic [7:0]              exp_num_next;
    logic [IW-1:0]           count_reg;
    logic [IW-1:0]           count_next;
    logic [7:0]              sum_reg;
    logic [7:0]              sum_next;
    logic [AW-1:0]           offset_reg;
    logic [AW-1:0]           offset_next;
    logic                    valid_reg;
    logic                    valid_next;
    xpr_pkg::result_t        result_reg;
    xpr_pkg::result_t        result_next;

    logic                    take;
    logic [7:0]              b;
    logic [AW:0]             last_page;
    logic                    over_limit;

    assign q_ready = !valid_reg || out_ready;
    assign take    = q_valid && q_ready;
    assign b       = q_item.data;

    // start of the last page written by this commit, one bit wider so it cannot wrap
    assign last_page  = {1'b0, offset_reg}
                      + (AW+1)'(xpr_pkg::PAYLOAD_BYTES - xpr_pkg::PAGE_BYTES);
    assign over_limit = (last_page >= (AW+1)'(app_end_offset));

    always_comb
    begin
        phase_next   = phase_reg;
        rx_num_next  = rx_num_reg;
        exp_num_next = exp_num_reg;
        count_next   = count_reg;
        sum_next     = sum_reg;
        offset_next  = offset_reg;
        valid_next   = valid_reg && !out_ready;
        result_next  = result_reg;

        if (take)
        begin
            result_next = '0;
            unique case (phase_reg)
                PH_START:
                begin
                    if (q_item.is_eot)
                    begin
                        phase_next          = PH_DONE;
                        valid_next          = 1'b1;
                        result_next.kind    = xpr_pkg::KIND_END;
                        result_next.tx_byte = xpr_pkg::BYTE_ACK;
                    end
                    else if (q_item.is_soh)
                    begin
                        phase_next = PH_NUMBER;
                    end
                    else
                    begin
                        valid_next             = 1'b1;
                        result_next.kind       = xpr_pkg::KIND_NAK;
                        result_next.tx_byte    = xpr_pkg::BYTE_NAK;
                        result_next.error_code = xpr_pkg::ERR_START;
                    end
                end
                PH_NUMBER:
                begin
                    rx_num_next = b;
                    phase_next  = PH_COMPL;
                end
                PH_COMPL:
                begin
                    if (enable_checks && (~b != rx_num_reg))
                    begin
                        phase_next             = PH_START;
                        valid_next             = 1'b1;
                        result_next.kind       = xpr_pkg::KIND_NAK;
                        result_next.tx_byte    = xpr_pkg::BYTE_NAK;
                        result_next.error_code = xpr_pkg::ERR_INVERT;
                    end
                    else if (enable_checks && (exp_num_reg != rx_num_reg))
                    begin
                        phase_next             = PH_START;
                        valid_next             = 1'b1;
                        result_next.kind       = xpr_pkg::KIND_NAK;
                        result_next.tx_byte    = xpr_pkg::BYTE_NAK;
                        result_next.error_code = xpr_pkg::ERR_ORDER;
                    end
                    else
                    begin
                        count_next = '0;
                        sum_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
                PH_DATA:
                begin
                    sum_next                = sum_reg + b;
                    valid_next              = 1'b1;
                    result_next.kind        = xpr_pkg::KIND_STAGE;
                    result_next.stage_index = count_reg;
                    result_next.stage_data  = b;
                    if (count_reg == IW'(xpr_pkg::PAYLOAD_BYTES - 1))
                    begin
                        count_next = '0;
                        phase_next = PH_SUM;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                PH_SUM:
                begin
                    valid_next = 1'b1;
                    if (enable_checks && (b != sum_reg))
                    begin
                        phase_next             = PH_START;
                        result_next.kind       = xpr_pkg::KIND_NAK;
                        result_next.tx_byte    = xpr_pkg::BYTE_NAK;
                        result_next.error_code = xpr_pkg::ERR_CHECKSUM;
                    end
                    else
                    begin
                        if (enable_checks)
                        begin
                            exp_num_next = exp_num_reg + 1'b1;
                        end
                        result_next.flash_offset = 16'(offset_reg);
                        if (enable_checks && over_limit)
                        begin
                            phase_next             = PH_HALT;
                            result_next.kind       = xpr_pkg::KIND_FATAL;
                            result_next.tx_byte    = xpr_pkg::BYTE_FATAL;
                            result_next.error_code = xpr_pkg::ERR_ADDRESS;
                        end
                        else
                        begin
                            offset_next         = offset_reg + AW'(xpr_pkg::PAYLOAD_BYTES);
                            phase_next          = PH_START;
                            result_next.kind    = xpr_pkg::KIND_COMMIT;
                            result_next.tx_byte = xpr_pkg::BYTE_ACK;
                        end
                    end
                end
                PH_DONE, PH_HALT:
                begin
                    // transfer over: bytes are dropped
                    result_next = result_reg;
                end
                default:
                begin
                    result_next = result_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_START;
            rx_num_reg  <= '0;
            exp_num_reg <= 8'd1;
            count_reg   <= '0;
            sum_reg     <= '0;
            offset_reg  <= '0;
            valid_reg   <= 1'b0;
            result_reg  <= '0;
        end
        else
        begin
            phase_reg   <= phase_next;
            rx_num_reg  <= rx_num_next;
            exp_num_reg <= exp_num_next;
            count_reg   <= count_next;
            sum_reg     <= sum_next;
            offset_reg  <= offset_next;
            valid_reg   <= valid_next;
            result_reg  <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

FILE: hdl/xmodem_packet_receiver.sv
// a result is registered by the packet engine after its byte passes the input stage and the queue
// throughput: one byte per cycle while m_tready stays high, set by the single-step packet engine
// input stage, four-entry queue and output register let either side stall alone
// reset: asynchronous active low, parser waits for a start byte, offset 0
// ----------------------------------------------------------------------------
// xmodem_packet_receiver
// xmodem checksum packet receiver with staging writes and commit results
// ----------------------------------------------------------------------------
module xmodem_packet_receiver
(
    input  logic                            clk,
    input  logic                            rst_n,
    // slave stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,  // rx_byte[7:0]
    // master stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // tx_byte[7:0], stage_index[14:8], stage_data[22:15], flash_offset[38:23],
    // error_code[41:39], zero fill above
    output logic [xpr_pkg::TDATA_BITS-1:0]  m_tdata,
    output logic [2:0]                      m_tuser,  // kind[2:0]
    // configuration
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [2:0]                      paddr,
    input  logic [31:0]                     pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready
);

    logic               enable_checks_reg;
    logic [15:0]        app_end_offset_reg;
    logic               cfg_write;

    logic               front_valid;
    xpr_pkg::rx_item_t  front_item;
    logic               q_wr_ready;
    logic               q_rd_valid;
    logic               q_rd_ready;
    xpr_pkg::rx_item_t  q_rd_item;
    xpr_pkg::result_t   result;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_checks_reg  <= xpr_pkg::ENABLE_CHECKS_RESET;
            app_end_offset_reg <= xpr_pkg::APP_END_OFFSET_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                xpr_pkg::REG_ENABLE_CHECKS:  enable_checks_reg  <= pwdata[0];
                xpr_pkg::REG_APP_END_OFFSET: app_end_offset_reg <= pwdata[15:0];
                default:                     enable_checks_reg  <= enable_checks_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            xpr_pkg::REG_ENABLE_CHECKS:  prdata = {31'd0, enable_checks_reg};
            xpr_pkg::REG_APP_END_OFFSET: prdata = {16'd0, app_end_offset_reg};
            default:                     prdata = '0;
        endcase
    end

    xpr_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_byte    (s_tdata),
        .q_valid    (front_valid),
        .q_ready    (q_wr_ready),
        .q_item     (front_item)
    );

    xpr_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (front_valid),
        .wr_ready (q_wr_ready),
        .wr_item  (front_item),
        .rd_valid (q_rd_valid),
        .rd_ready (q_rd_ready),
        .rd_item  (q_rd_item)
    );

    xpr_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .enable_checks  (enable_checks_reg),
        .app_end_offset (app_end_offset_reg),
        .q_valid        (q_rd_valid),
        .q_ready        (q_rd_ready),
        .q_item         (q_rd_item),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_result     (result)
    );

    assign m_tuser = result.kind;
    assign m_tdata = xpr_pkg::TDATA_BITS'({result.error_code, result.flash_offset,
                                           result.stage_data, result.stage_index,
                                           result.tx_byte});

endmodule

FILE: hdl/xpr_checker.sv
// ----------------------------------------------------------------------------
// xpr_checker
// port-level checks of the xmodem receiver, bound to the top level
// ----------------------------------------------------------------------------
module xpr_checker
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [xpr_pkg::TDATA_BITS-1:0]  m_tdata,
    input  logic [2:0]                      m_tuser,
    input  logic                            pready
);

    // a stalled result transaction holds its payload
    property p_hold;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser);
    endproperty
    a_hold: assert property (p_hold) else $error("result changed while stalled");

    // staging writes carry no transmit byte and no error
    property p_stage;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == xpr_pkg::KIND_STAGE)
            |-> (m_tdata[7:0] == 8'd0) && (m_tdata[41:39] == xpr_pkg::ERR_NONE);
    endproperty
    a_stage: assert property (p_stage) else $error("staging write with tx byte or error");

    // a nak always names its cause
    property p_nak;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == xpr_pkg::KIND_NAK)
            |-> (m_tdata[7:0] == xpr_pkg::BYTE_NAK) && (m_tdata[41:39] != xpr_pkg::ERR_NONE);
    endproperty
    a_nak: assert property (p_nak) else $error("nak without error code");

    // after an end ack or a fatal result no new transaction appears
    property p_stop;
        @(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready
            && ((m_tuser == xpr_pkg::KIND_END) || (m_tuser == xpr_pkg::KIND_FATAL))
            |=> !m_tvalid;
    endproperty
    a_stop: assert property (p_stop) else $error("result after transfer end");

    property p_pready;
        @(posedge clk) disable iff (!rst_n)
        pready;
    endproperty
    a_pready: assert property (p_pready) else $error("pready low");

endmodule

bind xmodem_packet_receiver xpr_checker u_xpr_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .pready   (pready)
);
